/* design/c12_pkg.sv */
package c12_pkg;

	// Frame limits and CRC constants.
	localparam int          MAX_FRAME     = 4096;
	localparam logic [16:0] PAY_LIMIT     = 17'(MAX_FRAME - 2);
	localparam logic [12:0] POS_MAX       = 13'h1FFF;
	localparam logic [11:0] MAX_LEN_RESET = 12'd4094;
	localparam logic [11:0] CRC_POLY      = 12'h80F;

	// Status codes reported with the last byte of a frame.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_SHORT    = 2'd2;
	localparam logic [1:0] STATUS_LONG     = 2'd3;

	typedef enum logic [1:0] {
		KIND_HDR0,
		KIND_HDR1,
		KIND_PAYLOAD
	} c12_kind_t;

	// A classified byte on its way from the front end to the back end.
	typedef struct packed {
		c12_kind_t   kind;
		logic [7:0]  data;
		logic        last;
		logic        over;
	} c12_item_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       frame_end;
		logic [1:0] frame_status;
		logic [3:0] message_type;
	} c12_result_t;

	// One byte through the CRC-12, most significant bit first.
	function automatic logic [11:0] crc_byte(logic [11:0] crc, logic [7:0] b);
		logic [11:0] c;
		c = crc ^ {b, 4'b0000};
		for (int i = 0; i < 8; i++) begin
			c = c[11] ? ({c[10:0], 1'b0} ^ CRC_POLY) : {c[10:0], 1'b0};
		end
		return c;
	endfunction

endpackage

/* design/c12_in_if.sv */
interface c12_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* design/c12_cfg_if.sv */
interface c12_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] max_payload_len;

	modport source (output valid, output max_payload_len, input ready);
	modport sink   (input valid, input max_payload_len, output ready);
endinterface

/* design/c12_out_if.sv */
interface c12_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       frame_end;
	logic [1:0] frame_status;
	logic [3:0] message_type;

	modport source (output valid, output payload_byte, output payload_valid,
		output frame_end, output frame_status, output message_type, input ready);
	modport sink   (input valid, input payload_byte, input payload_valid,
		input frame_end, input frame_status, input message_type, output ready);
endinterface

/* design/c12_front.sv */
module c12_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                cfg_we,
	input  logic [11:0]         cfg_data,
	output c12_pkg::c12_item_t  item
);

	logic [12:0] pos_q;
	logic        overlong_q;
	logic [11:0] max_len_q;
	logic [12:0] count;
	logic        over_now;

	// Payload count including this byte is the position minus one.
	assign count    = pos_q - 13'd1;
	assign over_now = (count > {1'b0, max_len_q}) || ({4'b0, count} > c12_pkg::PAY_LIMIT);

	always_comb begin
		item.data = data_byte;
		item.last = last_byte;
		item.over = overlong_q;
		if (pos_q == 13'd0) begin
			item.kind = c12_pkg::KIND_HDR0;
		end else if (pos_q == 13'd1) begin
			item.kind = c12_pkg::KIND_HDR1;
		end else begin
			item.kind = c12_pkg::KIND_PAYLOAD;
			item.over = overlong_q | over_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			overlong_q <= 1'b0;
			max_len_q  <= c12_pkg::MAX_LEN_RESET;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_data;
			end
			if (accept) begin
				if (last_byte) begin
					pos_q      <= '0;
					overlong_q <= 1'b0;
				end else begin
					overlong_q <= item.over;
					if (pos_q != c12_pkg::POS_MAX) begin
						pos_q <= pos_q + 13'd1;
					end
				end
			end
		end
	end

endmodule

/* design/c12_fifo.sv */
module c12_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  c12_pkg::c12_item_t  push_item,
	input  logic                pop,
	output c12_pkg::c12_item_t  pop_item,
	output logic                full,
	output logic                empty
);

	c12_pkg::c12_item_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/c12_back.sv */
module c12_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop,
	input  c12_pkg::c12_item_t   item,
	output c12_pkg::c12_result_t result
);

	logic [7:0]  hhigh_q;
	logic [3:0]  rtype_q;
	logic [11:0] rcheck_q;
	logic [11:0] crc_q;

	logic [7:0]  hhigh_d;
	logic [3:0]  rtype_d;
	logic [11:0] rcheck_d;
	logic [11:0] crc_d;

	always_comb begin
		hhigh_d  = hhigh_q;
		rtype_d  = rtype_q;
		rcheck_d = rcheck_q;
		crc_d    = crc_q;
		result   = '0;
		unique case (item.kind)
			c12_pkg::KIND_HDR0: begin
				hhigh_d = item.data;
			end
			c12_pkg::KIND_HDR1: begin
				rcheck_d = {hhigh_q, item.data[7:4]};
				rtype_d  = item.data[3:0];
				crc_d    = c12_pkg::crc_byte(12'd0, {4'b0000, item.data[3:0]});
			end
			c12_pkg::KIND_PAYLOAD: begin
				crc_d                = c12_pkg::crc_byte(crc_q, item.data);
				result.payload_byte  = item.data;
				result.payload_valid = 1'b1;
			end
			default: begin
				hhigh_d = hhigh_q;
			end
		endcase
		result.message_type = rtype_d;
		result.frame_end    = item.last;
		if (item.last) begin
			priority if (item.kind == c12_pkg::KIND_HDR0) begin
				result.frame_status = c12_pkg::STATUS_SHORT;
			end else if (item.over) begin
				result.frame_status = c12_pkg::STATUS_LONG;
			end else if (crc_d != rcheck_d) begin
				result.frame_status = c12_pkg::STATUS_MISMATCH;
			end else begin
				result.frame_status = c12_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hhigh_q  <= '0;
			rtype_q  <= '0;
			rcheck_q <= '0;
			crc_q    <= '0;
		end else if (pop) begin
			if (item.last) begin
				hhigh_q  <= '0;
				rtype_q  <= '0;
				rcheck_q <= '0;
				crc_q    <= '0;
			end else begin
				hhigh_q  <= hhigh_d;
				rtype_q  <= rtype_d;
				rcheck_q <= rcheck_d;
				crc_q    <= crc_d;
			end
		end
	end

endmodule

/* design/crc12_frame_checker.sv */
// CRC-12 frame checker. Frame bytes enter on rx one per item, the last one
// flagged by last_byte, and every accepted byte gives exactly one item on tx.
// The first two bytes form a big-endian header whose upper 12 bits are the
// transmitted checksum and whose lower 4 bits are the message type; the CRC
// (polynomial 0x80F, initial value zero, MSB first, no final XOR) covers the
// type nibble and then every payload byte. Payload bytes are passed through
// with payload_valid set, and the item for the last byte carries frame_end
// with the status: ok, checksum mismatch, too short (frame of one byte) or
// too long (payload above max_payload_len or above MAX_FRAME - 2 bytes).
// The block sustains one item per clock while the sink keeps tx ready: the
// front end classifies and counts bytes as they are accepted, a two-entry
// queue decouples it from the back end, and the back end runs the eight-bit
// CRC update combinationally into the output register. An accepted byte
// passes through the queue and then the output register before it appears
// on tx. The cfg channel, always ready, sets max_payload_len
// (reset value 4094) and must only be written while no frame is in flight.
module crc12_frame_checker (
	input  logic       clk,
	input  logic       arst_n,
	c12_in_if.sink     rx,
	c12_cfg_if.sink    cfg,
	c12_out_if.source  tx
);

	c12_pkg::c12_item_t   push_item;
	c12_pkg::c12_item_t   pop_item;
	c12_pkg::c12_result_t result;
	c12_pkg::c12_result_t out_q;
	logic                 out_valid_q;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 empty;

	// The input is taken whenever the queue has room.
	assign rx.ready  = !full;
	assign push      = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	// The back end advances when the output register is free or being emptied.
	assign pop = !empty && (!out_valid_q || tx.ready);

	c12_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (push),
		.data_byte (rx.data_byte),
		.last_byte (rx.last_byte),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.max_payload_len),
		.item      (push_item)
	);

	c12_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (full),
		.empty     (empty)
	);

	c12_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop    (pop),
		.item   (pop_item),
		.result (result)
	);

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= result;
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.payload_byte  = out_q.payload_byte;
	assign tx.payload_valid = out_q.payload_valid;
	assign tx.frame_end     = out_q.frame_end;
	assign tx.frame_status  = out_q.frame_status;
	assign tx.message_type  = out_q.message_type;

`ifndef SYNTHESIS
	// A status is only reported on the last item of a frame.
	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && !tx.frame_end) |-> (tx.frame_status == c12_pkg::STATUS_OK))
		else $error("frame status set on an item that does not end a frame");

	// A frame of one byte carries neither payload nor a message type.
	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(tx.valid && tx.frame_end && tx.frame_status == c12_pkg::STATUS_SHORT)
		|-> (!tx.payload_valid && tx.message_type == 4'd0))
		else $error("short frame reported with payload or type");

	// Taking the last byte from the queue shows a frame end on the next cycle.
	a_end_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_item.last) |=> (tx.valid && tx.frame_end))
		else $error("last byte did not reach the output register");
`endif

endmodule

/* tb/crc12_frame_tb_pkg.sv */
`timescale 1ns / 1ps
package crc12_frame_tb_pkg;

	import c12_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// One byte into the CRC-12, one bit at a time, most significant bit first.
	function automatic logic [11:0] crc12_update(logic [11:0] crc, logic [7:0] b);
		logic [11:0] r;
		logic        fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[11] ^ b[i];
			r  = {r[10:0], 1'b0} ^ (fb ? CRC_POLY : 12'h000);
		end
		return r;
	endfunction

endpackage

/* tb/crc12_frame_status_checker.sv */
`timescale 1ns / 1ps
module crc12_frame_status_checker
	import c12_pkg::*;
	import crc12_frame_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	c12_in_if           rx,
	c12_cfg_if          cfg,
	c12_out_if          tx,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	logic [11:0] len_limit;
	logic [12:0] pos;
	logic [7:0]  hdr_high;
	logic [3:0]  rx_type;
	logic [11:0] sent_check;
	logic [11:0] crc;
	logic        too_long;
	c12_result_t predicted_out[$];

	always @(posedge clk or negedge arst_n) begin : watch
		c12_result_t res;
		c12_result_t want;
		c12_result_t got;
		logic [12:0] count;
		logic        first;
		if (!arst_n) begin
			len_limit   = MAX_LEN_RESET;
			pos         = '0;
			hdr_high    = '0;
			rx_type     = '0;
			sent_check  = '0;
			crc         = '0;
			too_long    = 1'b0;
			mismatches  = 0;
			outstanding = 0;
			predicted_out.delete();
		end else begin
			if (rx.valid && rx.ready) begin
				res   = '0;
				first = (pos == 13'd0);
				if (pos == 13'd0) begin
					hdr_high = rx.data_byte;
				end else if (pos == 13'd1) begin
					sent_check = {hdr_high, rx.data_byte[7:4]};
					rx_type    = rx.data_byte[3:0];
					crc        = crc12_update(12'h000, {4'h0, rx_type});
				end else begin
					count             = pos - 13'd1;
					res.payload_byte  = rx.data_byte;
					res.payload_valid = 1'b1;
					crc               = crc12_update(crc, rx.data_byte);
					if (count > {1'b0, len_limit} || count > 13'(PAY_LIMIT))
						too_long = 1'b1;
				end
				if (pos != POS_MAX)
					pos = pos + 13'd1;
				res.message_type = rx_type;
				if (rx.last_byte) begin
					res.frame_end = 1'b1;
					if (first)
						res.frame_status = STATUS_SHORT;
					else if (too_long)
						res.frame_status = STATUS_LONG;
					else if (crc != sent_check)
						res.frame_status = STATUS_MISMATCH;
					else
						res.frame_status = STATUS_OK;
					pos        = '0;
					hdr_high   = '0;
					rx_type    = '0;
					sent_check = '0;
					crc        = '0;
					too_long   = 1'b0;
				end
				predicted_out.push_back(res);
			end

			if (cfg.valid && cfg.ready)
				len_limit = cfg.max_payload_len;

			if (tx.valid && tx.ready) begin
				got.payload_byte  = tx.payload_byte;
				got.payload_valid = tx.payload_valid;
				got.frame_end     = tx.frame_end;
				got.frame_status  = tx.frame_status;
				got.message_type  = tx.message_type;
				if (predicted_out.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none pending: byte %h pv %b end %b st %0d type %h",
							$realtime, got.payload_byte, got.payload_valid, got.frame_end,
							got.frame_status, got.message_type);
				end else begin
					want = predicted_out.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: expected byte %h pv %b end %b st %0d type %h",
								$realtime, want.payload_byte, want.payload_valid,
								want.frame_end, want.frame_status, want.message_type);
							$display("%0t: actual   byte %h pv %b end %b st %0d type %h",
								$realtime, got.payload_byte, got.payload_valid,
								got.frame_end, got.frame_status, got.message_type);
						end
					end
				end
			end
			outstanding = predicted_out.size();
		end
	end

endmodule

/* tb/crc12_frame_checker_tb.sv */
`timescale 1ns / 1ps
module crc12_frame_checker_tb;

	import crc12_frame_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned byte_count = 0;

	// Each side switches now and then into a mode with no idling at all, so
	// that long back-to-back stretches alternate with randomly gapped ones.
	bit sender_calm = 1'b0;
	bit receiver_calm = 1'b0;

	c12_in_if  rx();
	c12_cfg_if cfg();
	c12_out_if tx();

	crc12_frame_checker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg),
		.tx     (tx)
	);

	// The checker watches all three channels, predicts every result item and
	// compares; this module only drives stimulus and gives the verdict.
	crc12_frame_status_checker i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.cfg         (cfg),
		.tx          (tx),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// Hard stop in case the block hangs. The slowest legal run, with every
	// item waiting out the longest gap and the longest stall, stays well
	// below this.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Output side: before every item a random number of stall cycles, then
	// ready stays high until the item has been taken.
	initial begin : drain
		int unsigned stall;
		bit          took;
		tx.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				receiver_calm = !receiver_calm;
			stall = receiver_calm ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				tx.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			tx.ready = 1'b1;
			do begin
				@(posedge clk);
				took = tx.valid;
				@(negedge clk);
			end while (!took);
		end
	end

	// Drives one frame byte. It is entered and left at a falling edge; valid
	// stays high on return so that a following item can go out back to back,
	// and whoever pauses the input stream lowers it first.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int unsigned gap;
		bit          taken;
		if ($urandom_range(0, 31) == 0)
			sender_calm = !sender_calm;
		gap = sender_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			rx.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid     = 1'b1;
		rx.data_byte = b;
		rx.last_byte = is_last;
		do begin
			@(posedge clk);
			taken = rx.ready;
			@(negedge clk);
		end while (!taken);
		byte_count++;
	endtask

	// Sends a whole frame: the header carries the CRC over the type nibble
	// and the payload, with flip XORed into it to force a checksum error.
	task automatic send_frame(input logic [3:0] mtype, input byte_q_t body,
			input logic [11:0] flip);
		logic [11:0] chk;
		chk = crc12_update(12'h000, {4'h0, mtype});
		foreach (body[i])
			chk = crc12_update(chk, body[i]);
		chk = chk ^ flip;
		send_byte(chk[11:4], 1'b0);
		send_byte({chk[3:0], mtype}, body.size() == 0);
		foreach (body[i])
			send_byte(body[i], i == body.size() - 1);
	endtask

	function automatic byte_q_t random_body(input int n);
		byte_q_t q;
		for (int i = 0; i < n; i++)
			q.push_back(8'($urandom));
		return q;
	endfunction

	// The limit register may only change between frames, so the input stream
	// is paused and every result has to come back before the write.
	task automatic set_limit(input logic [11:0] v);
		bit taken;
		rx.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg.valid           = 1'b1;
		cfg.max_payload_len = v;
		do begin
			@(posedge clk);
			taken = cfg.ready;
			@(negedge clk);
		end while (!taken);
		cfg.valid = 1'b0;
	endtask

	initial begin : stimulus
		byte_q_t     body;
		byte_q_t     no_payload;
		logic [11:0] limits[8];
		int unsigned phase_start;
		int unsigned pick;
		int          len;
		rx.valid            = 1'b0;
		rx.data_byte        = '0;
		rx.last_byte        = 1'b0;
		cfg.valid           = 1'b0;
		cfg.max_payload_len = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part, under the reset limit of 4094 first. Single-byte
		// frames are too short, whatever their value.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// Two-byte frames have an empty payload: the CRC covers only the type.
		send_frame(4'hF, no_payload, 12'h000);
		send_frame(4'h0, no_payload, 12'h001);
		body = '{8'h00, 8'hFF};
		send_frame(4'hA, body, 12'h000);
		body = '{8'hFF, 8'h80, 8'h01};
		send_frame(4'h5, body, 12'h800);
		// With a limit of zero any payload byte makes the frame too long, and
		// that outranks a bad checksum.
		set_limit(12'd0);
		send_frame(4'h3, no_payload, 12'h000);
		body = '{8'h7F};
		send_frame(4'hC, body, 12'h0FF);
		// One above the largest meaningful limit is taken as written.
		set_limit(12'd4095);
		body = '{8'h55, 8'hAA};
		send_frame(4'h9, body, 12'h000);

		// Random part. Most frames are well formed with random content so
		// that the CRC and the length check see real traffic; the rest are
		// corrupted headers and single-byte frames. Short limits make the
		// too-long status frequent.
		limits = '{12'd4094, 12'd0, 12'd1, 12'd4095,
			12'($urandom_range(2, 40)), 12'($urandom_range(2, 40)),
			12'($urandom_range(2, 40)), 12'($urandom_range(2, 40))};
		foreach (limits[p]) begin
			set_limit(limits[p]);
			phase_start = byte_count;
			while (byte_count - phase_start < 200) begin
				pick = $urandom_range(0, 99);
				len  = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48)
					: $urandom_range(0, 12);
				if (pick < 8)
					send_byte(8'($urandom), 1'b1);
				else if (pick < 22)
					send_frame(4'($urandom), random_body(len),
						12'($urandom_range(1, 4095)));
				else
					send_frame(4'($urandom), random_body(len), 12'h000);
			end
		end

		// Drain: every prediction must be matched, then a short quiet spell
		// catches any stray result item.
		rx.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
